### rtl/core/meter_frame_receive_parser_defines.svh
// Assertion helpers used by the parser checker.
`ifndef METER_FRAME_RECEIVE_PARSER_DEFINES_SVH
`define METER_FRAME_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication on the i_clk edge, off during reset.
`define MFRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on the i_clk edge, off during reset.
`define MFRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mfrp_pkg.sv
package mfrp_pkg;

    typedef logic [3:0] t_status;

    localparam t_status ST_OK       = 4'd0;
    localparam t_status ST_START2   = 4'd1;
    localparam t_status ST_CHECKSUM = 4'd2;
    localparam t_status ST_STOP     = 4'd3;
    localparam t_status ST_ADDRESS  = 4'd4;
    localparam t_status ST_ABNORMAL = 4'd5;
    localparam t_status ST_CONTROL  = 4'd6;
    localparam t_status ST_SHORT    = 4'd7;
    localparam t_status ST_IDENT    = 4'd8;

    localparam logic [7:0] START_BYTE    = 8'h68;
    localparam logic [7:0] STOP_BYTE     = 8'h16;
    localparam logic [7:0] CTRL_NORMAL   = 8'h83;
    localparam logic [7:0] CTRL_ABNORMAL = 8'hC3;
    localparam logic [7:0] SCRAMBLE      = 8'h33;

    localparam int ADDR_BYTES  = 6;
    localparam int IDENT_BYTES = 4;
    localparam int ADDR_W      = 8 * ADDR_BYTES;
    localparam int IDENT_W     = 8 * IDENT_BYTES;

    localparam logic [7:0] MAX_PAYLOAD_COUNT = 8'd251;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_ADDR_MATCH_EN = 2'd0;
    localparam t_cfg_index CFG_METER_ADDRESS = 2'd1;
    localparam t_cfg_index CFG_EXPECTED_IDENT = 2'd2;

endpackage

### rtl/core/meter_frame_receive_parser.sv
// Meter reply frame receive parser.
// Input channel: one received byte per beat on i_rx_byte (i_in_valid / o_in_ready).
// Bytes ahead of a 0x68 start byte are dropped; the frame is then walked by position.
// Output channel (o_out_valid / i_out_ready): a data beat (result_kind 0) for each
// unscrambled payload byte after the four identifier bytes, and one status beat
// (result_kind 1, frame_end 1) at the stop-byte position carrying status, address,
// identifier and payload count. Data beats go out before the frame is judged.
// A result is registered in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle unless a stalled result blocks it; the per-byte
// update is one 8-bit add and compares between the frame state and the result register.
// Stall: while a result waits, a new beat is still taken in the cycle the receiver
// takes the waiting one; with the receiver stalled and a result held, o_in_ready
// stays low.
// Reset (synchronous, active low): hunting for a start byte, no result pending,
// all configuration registers zero.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_index (0 address
// match enable, 1 meter address, 2 expected identifier); write only while idle.
module meter_frame_receive_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_data_byte,
    output logic [3:0]  o_frame_status,
    output logic [47:0] o_frame_address,
    output logic [31:0] o_frame_ident,
    output logic [7:0]  o_payload_count,
    output logic        o_frame_end,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_wdata
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_ADDR, PH_START2, PH_CTRL, PH_LEN, PH_DATA, PH_CS, PH_STOP
    } t_phase;

    logic                              r_addr_match_en;
    logic [mfrp_pkg::ADDR_W-1:0]       r_meter_address;
    logic [mfrp_pkg::IDENT_W-1:0]      r_expected_ident;

    t_phase                            r_phase, n_phase;
    logic [7:0]                        r_idx, n_idx;
    logic [7:0]                        r_len, n_len;
    logic [7:0]                        r_sum, n_sum;
    logic [mfrp_pkg::ADDR_W-1:0]       r_addr, n_addr;
    logic [mfrp_pkg::IDENT_W-1:0]      r_ident, n_ident;
    logic [7:0]                        r_ctrl, n_ctrl;
    mfrp_pkg::t_status                 r_err, n_err;

    logic                              r_out_valid;
    logic                              r_kind, n_kind;
    logic [7:0]                        r_data, n_data;
    mfrp_pkg::t_status                 r_status, n_status;
    logic [mfrp_pkg::ADDR_W-1:0]       r_res_addr, n_res_addr;
    logic [mfrp_pkg::IDENT_W-1:0]      r_res_ident, n_res_ident;
    logic [7:0]                        r_count, n_count;
    logic                              n_emit;

    logic                              accept;
    logic [7:0]                        sum_add;
    logic [7:0]                        unscr;
    logic [8:0]                        idx_inc;
    mfrp_pkg::t_status                 judge;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign sum_add    = r_sum + i_rx_byte;
    assign unscr      = i_rx_byte - mfrp_pkg::SCRAMBLE;
    assign idx_inc    = {1'b0, r_idx} + 9'd1;

    always_comb begin
        judge = r_err;
        if (i_rx_byte != mfrp_pkg::STOP_BYTE && r_err == mfrp_pkg::ST_OK) begin
            judge = mfrp_pkg::ST_STOP;
        end
        if (judge == mfrp_pkg::ST_OK) begin
            if (r_addr_match_en && r_addr != r_meter_address) begin
                judge = mfrp_pkg::ST_ADDRESS;
            end else if (r_ctrl == mfrp_pkg::CTRL_ABNORMAL) begin
                judge = mfrp_pkg::ST_ABNORMAL;
            end else if (r_ctrl != mfrp_pkg::CTRL_NORMAL) begin
                judge = mfrp_pkg::ST_CONTROL;
            end else if (r_len <= 8'(mfrp_pkg::IDENT_BYTES)) begin
                judge = mfrp_pkg::ST_SHORT;
            end else if (r_expected_ident != '0 && r_ident != r_expected_ident) begin
                judge = mfrp_pkg::ST_IDENT;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_len       = r_len;
        n_sum       = r_sum;
        n_addr      = r_addr;
        n_ident     = r_ident;
        n_ctrl      = r_ctrl;
        n_err       = r_err;
        n_emit      = 1'b0;
        n_kind      = 1'b0;
        n_data      = '0;
        n_status    = mfrp_pkg::ST_OK;
        n_res_addr  = '0;
        n_res_ident = '0;
        n_count     = '0;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == mfrp_pkg::START_BYTE) begin
                    n_phase = PH_ADDR;
                    n_idx   = '0;
                    n_len   = '0;
                    n_sum   = i_rx_byte;
                    n_addr  = '0;
                    n_ident = '0;
                    n_ctrl  = '0;
                    n_err   = mfrp_pkg::ST_OK;
                end
            end
            PH_ADDR: begin
                n_sum = sum_add;
                for (int k = 0; k < mfrp_pkg::ADDR_BYTES; k++) begin
                    if (r_idx == 8'(k)) begin
                        n_addr[8*k +: 8] = i_rx_byte;
                    end
                end
                if (r_idx == 8'(mfrp_pkg::ADDR_BYTES - 1)) begin
                    n_idx   = '0;
                    n_phase = PH_START2;
                end else begin
                    n_idx = idx_inc[7:0];
                end
            end
            PH_START2: begin
                n_sum   = sum_add;
                n_phase = PH_CTRL;
                if (i_rx_byte != mfrp_pkg::START_BYTE && r_err == mfrp_pkg::ST_OK) begin
                    n_err = mfrp_pkg::ST_START2;
                end
            end
            PH_CTRL: begin
                n_sum   = sum_add;
                n_ctrl  = i_rx_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_sum   = sum_add;
                n_len   = i_rx_byte;
                n_idx   = '0;
                n_phase = (i_rx_byte == 8'd0) ? PH_CS : PH_DATA;
            end
            PH_DATA: begin
                n_sum = sum_add;
                if (r_idx < 8'(mfrp_pkg::IDENT_BYTES)) begin
                    for (int k = 0; k < mfrp_pkg::IDENT_BYTES; k++) begin
                        if (r_idx == 8'(k)) begin
                            n_ident[8*k +: 8] = unscr;
                        end
                    end
                end else begin
                    n_emit = 1'b1;
                    n_data = unscr;
                end
                n_idx = idx_inc[7:0];
                if (idx_inc >= {1'b0, r_len}) begin
                    n_phase = PH_CS;
                end
            end
            PH_CS: begin
                n_phase = PH_STOP;
                if (i_rx_byte != r_sum && r_err == mfrp_pkg::ST_OK) begin
                    n_err = mfrp_pkg::ST_CHECKSUM;
                end
            end
            PH_STOP: begin
                n_emit      = 1'b1;
                n_kind      = 1'b1;
                n_status    = judge;
                n_res_addr  = r_addr;
                n_res_ident = r_ident;
                n_count     = (r_len > 8'(mfrp_pkg::IDENT_BYTES))
                              ? r_len - 8'(mfrp_pkg::IDENT_BYTES) : 8'd0;
                n_phase     = PH_HUNT;
                n_idx       = '0;
                n_len       = '0;
                n_sum       = '0;
                n_addr      = '0;
                n_ident     = '0;
                n_ctrl      = '0;
                n_err       = mfrp_pkg::ST_OK;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_match_en  <= 1'b0;
            r_meter_address  <= '0;
            r_expected_ident <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mfrp_pkg::CFG_ADDR_MATCH_EN:  r_addr_match_en  <= i_cfg_wdata[0];
                mfrp_pkg::CFG_METER_ADDRESS:  r_meter_address  <= i_cfg_wdata;
                mfrp_pkg::CFG_EXPECTED_IDENT: r_expected_ident <=
                                                  i_cfg_wdata[mfrp_pkg::IDENT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_idx       <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_addr      <= '0;
            r_ident     <= '0;
            r_ctrl      <= '0;
            r_err       <= mfrp_pkg::ST_OK;
            r_out_valid <= 1'b0;
            r_kind      <= 1'b0;
            r_data      <= '0;
            r_status    <= mfrp_pkg::ST_OK;
            r_res_addr  <= '0;
            r_res_ident <= '0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_len   <= n_len;
                r_sum   <= n_sum;
                r_addr  <= n_addr;
                r_ident <= n_ident;
                r_ctrl  <= n_ctrl;
                r_err   <= n_err;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
                r_kind      <= n_kind;
                r_data      <= n_data;
                r_status    <= n_status;
                r_res_addr  <= n_res_addr;
                r_res_ident <= n_res_ident;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_data_byte     = r_data;
    assign o_frame_status  = r_status;
    assign o_frame_address = r_res_addr;
    assign o_frame_ident   = r_res_ident;
    assign o_payload_count = r_count;
    assign o_frame_end     = r_kind;

endmodule

### rtl/core/mfrp_checker.sv
`include "meter_frame_receive_parser_defines.svh"

module mfrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_rx_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_result_kind,
    input logic [7:0]  o_data_byte,
    input logic [3:0]  o_frame_status,
    input logic [47:0] o_frame_address,
    input logic [31:0] o_frame_ident,
    input logic [7:0]  o_payload_count,
    input logic        o_frame_end,
    input logic        i_cfg_wr_en,
    input logic [1:0]  i_cfg_index,
    input logic [47:0] i_cfg_wdata
);

    `MFRP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_result_kind) && $stable(o_data_byte) && $stable(o_frame_status) && $stable(o_frame_address) && $stable(o_frame_ident) && $stable(o_payload_count), "stalled result beat changed")
    `MFRP_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready, "input stalled with no result pending")
    `MFRP_ASSERT_NOW(a_data_beat_clean, o_out_valid && !o_result_kind, !o_frame_end && o_frame_status == mfrp_pkg::ST_OK && o_frame_address == '0 && o_frame_ident == '0 && o_payload_count == '0, "data beat carries status fields")
    `MFRP_ASSERT_NOW(a_status_beat_range, o_out_valid && o_result_kind, o_frame_end && o_data_byte == '0 && o_frame_status <= mfrp_pkg::ST_IDENT && o_payload_count <= mfrp_pkg::MAX_PAYLOAD_COUNT, "status beat out of range")

endmodule

bind meter_frame_receive_parser mfrp_checker u_mfrp_checker (.*);
